// ===== rtl/msd_pkg.sv =====
// shared types and constants for the sample mean and standard deviation block
`timescale 1ns / 1ps
`default_nettype none

package msd_pkg;

    // fixed field widths of the transaction payloads
    localparam int VALUE_W  = 16;
    localparam int TOTAL_W  = 11;
    localparam int STATUS_W = 2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FEW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVF = 2'd2;

    // largest reportable deviation
    localparam logic [VALUE_W-1:0] SD_MAX = 16'hFFFF;

    // controller states
    typedef enum logic [3:0] {
        S_ACCUM,
        S_LD_A,
        S_RUN_A,
        S_LD_B,
        S_RUN_B,
        S_LD_D,
        S_RUN_D,
        S_LD_M,
        S_RUN_M,
        S_LD_V,
        S_RUN_V,
        S_LD_R,
        S_RUN_R,
        S_DONE
    } msd_state_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LD_A,
        OP_LD_B,
        OP_LD_D,
        OP_LD_M,
        OP_LD_V,
        OP_LD_R,
        OP_MUL_STEP,
        OP_DIV_STEP,
        OP_ROOT_STEP,
        OP_PUBLISH
    } msd_op_t;

    // controller to datapath commands
    typedef struct packed {
        msd_op_t op;
        logic    take;
    } msd_ctl_t;

    // datapath to controller status
    typedef struct packed {
        logic last_pending;
        logic out_free;
    } msd_sts_t;

endpackage

`default_nettype wire

// ===== rtl/msd_if.sv =====
// valid/ready channel interfaces for samples and results
`timescale 1ns / 1ps
`default_nettype none

interface msd_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [msd_pkg::VALUE_W-1:0] sample;
    logic                               last;

    modport source (output valid, output sample, output last, input ready);
    modport sink (input valid, input sample, input last, output ready);
endinterface

interface msd_out_if;
    logic                          valid;
    logic                          ready;
    logic [msd_pkg::TOTAL_W-1:0]   sample_total;
    logic signed [msd_pkg::VALUE_W-1:0] mean_value;
    logic [msd_pkg::VALUE_W-1:0]   std_deviation;
    logic [msd_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output sample_total, output mean_value,
                    output std_deviation, output status, input ready);
    modport sink (input valid, input sample_total, input mean_value,
                  input std_deviation, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/msd_datapath.sv =====
// accumulators, shared multiplier, divider, square root unit and result register
`timescale 1ns / 1ps
`default_nettype none

module msd_datapath #(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire msd_pkg::msd_ctl_t ctl,
    output msd_pkg::msd_sts_t     sts,
    msd_in_if.sink                samples,
    msd_out_if.source             results
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SQ_W  = 2 * SAMPLE_BITS - 1;
    localparam int SUM_W = CNT_W + SAMPLE_BITS;
    localparam int SQS_W = SQ_W + CNT_W;
    localparam int NUM_W = (CNT_W + SQS_W > 64) ? 64 : CNT_W + SQS_W;
    localparam int DEN_W = 2 * CNT_W;
    localparam int RT_W  = NUM_W + NUM_W % 2;

    // input stage
    logic                          in_fire;
    logic signed [SAMPLE_BITS-1:0] samp_w;
    logic                          p_valid_reg;
    logic                          p_last_reg;
    logic signed [SAMPLE_BITS-1:0] p_samp_reg;
    logic [SQ_W-1:0]               p_sq_reg;

    // accumulators
    logic [CNT_W-1:0]        n_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [SQS_W-1:0]        sq_reg;
    logic                    ovf_reg;

    // shared shift-add multiplier
    logic [NUM_W-1:0] acc_reg;
    logic [NUM_W-1:0] mcand_reg;
    logic [SUM_W-1:0] mplier_reg;

    // intermediate terms
    logic [NUM_W-1:0] a_reg;
    logic [NUM_W-1:0] b_reg;
    logic [DEN_W-1:0] den_reg;
    logic signed [SAMPLE_BITS-1:0] mean_reg;

    // restoring divider
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] dvs_reg;
    logic [DEN_W:0]   div_sh;
    logic [DEN_W:0]   div_diff;

    // square root
    logic [RT_W-1:0] x_reg;
    logic [RT_W-1:0] r_reg;
    logic [RT_W-1:0] bit_reg;
    logic [RT_W-1:0] root_t;
    logic            root_ge;

    // result register
    logic                         out_valid_reg;
    logic [msd_pkg::TOTAL_W-1:0]  out_total_reg;
    logic signed [msd_pkg::VALUE_W-1:0] out_mean_reg;
    logic [msd_pkg::VALUE_W-1:0]  out_sd_reg;
    logic [msd_pkg::STATUS_W-1:0] out_status_reg;

    // derived values
    logic                   sum_neg;
    logic [SUM_W-1:0]       mag;
    logic [NUM_W-1:0]       num;
    logic [SAMPLE_BITS-1:0] q_lo;
    logic [msd_pkg::VALUE_W-1:0] sd_val;
    logic                   few;

    // input handshake
    assign samples.ready = ctl.take;
    assign in_fire       = samples.valid && ctl.take;
    assign samp_w        = samples.sample[SAMPLE_BITS-1:0];

    // status to the controller
    assign sts.last_pending = p_valid_reg && p_last_reg;
    assign sts.out_free     = !out_valid_reg || results.ready;

    // magnitude of the sum and the variance numerator
    assign sum_neg = sum_reg[SUM_W-1];
    assign mag     = sum_neg ? (~sum_reg + SUM_W'(1)) : sum_reg;
    assign num     = (a_reg > b_reg) ? (a_reg - b_reg) : '0;

    // divider trial subtraction
    assign div_sh   = {rem_reg, quo_reg[NUM_W-1]};
    assign div_diff = div_sh - {1'b0, dvs_reg};

    // root trial compare
    assign root_t  = r_reg + bit_reg;
    assign root_ge = x_reg >= root_t;

    // result formatting
    assign q_lo   = quo_reg[SAMPLE_BITS-1:0];
    assign few    = n_reg < CNT_W'(2);
    assign sd_val = (64'(r_reg) > 64'(msd_pkg::SD_MAX)) ? msd_pkg::SD_MAX
                                                         : msd_pkg::VALUE_W'(r_reg);

    // input stage and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            n_reg       <= '0;
            sum_reg     <= '0;
            sq_reg      <= '0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            p_valid_reg <= in_fire;
            if (ctl.op == msd_pkg::OP_PUBLISH)
            begin
                n_reg   <= '0;
                sum_reg <= '0;
                sq_reg  <= '0;
                ovf_reg <= 1'b0;
            end
            else if (p_valid_reg)
            begin
                if (n_reg < CNT_W'(MAX_SAMPLES))
                begin
                    n_reg   <= n_reg + CNT_W'(1);
                    sum_reg <= sum_reg + SUM_W'(p_samp_reg);
                    sq_reg  <= sq_reg + SQS_W'(p_sq_reg);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
        end
    end

    // registered sample and its square
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            p_last_reg <= samples.last;
            p_samp_reg <= samp_w;
            p_sq_reg   <= SQ_W'(samp_w * samp_w);
        end
    end

    // arithmetic units, stepped by the controller
    always_ff @(posedge clk)
    begin
        case (ctl.op)
            msd_pkg::OP_LD_A:
            begin
                acc_reg    <= '0;
                mcand_reg  <= NUM_W'(sq_reg);
                mplier_reg <= SUM_W'(n_reg);
            end
            msd_pkg::OP_LD_B:
            begin
                a_reg      <= acc_reg;
                acc_reg    <= '0;
                mcand_reg  <= NUM_W'(mag);
                mplier_reg <= mag;
            end
            msd_pkg::OP_LD_D:
            begin
                b_reg      <= acc_reg;
                acc_reg    <= '0;
                mcand_reg  <= NUM_W'(n_reg - CNT_W'(1));
                mplier_reg <= SUM_W'(n_reg);
            end
            msd_pkg::OP_MUL_STEP:
            begin
                if (mplier_reg[0])
                begin
                    acc_reg <= acc_reg + mcand_reg;
                end
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
            end
            msd_pkg::OP_LD_M:
            begin
                den_reg <= acc_reg[DEN_W-1:0];
                quo_reg <= NUM_W'(mag);
                rem_reg <= '0;
                dvs_reg <= DEN_W'(n_reg);
            end
            msd_pkg::OP_LD_V:
            begin
                mean_reg <= sum_neg ? (~q_lo + SAMPLE_BITS'(1)) : q_lo;
                quo_reg  <= num;
                rem_reg  <= '0;
                dvs_reg  <= den_reg;
            end
            msd_pkg::OP_DIV_STEP:
            begin
                if (!div_diff[DEN_W])
                begin
                    rem_reg <= div_diff[DEN_W-1:0];
                    quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= div_sh[DEN_W-1:0];
                    quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
                end
            end
            msd_pkg::OP_LD_R:
            begin
                x_reg   <= RT_W'(quo_reg);
                r_reg   <= '0;
                bit_reg <= {2'b01, {(RT_W - 2){1'b0}}};
            end
            msd_pkg::OP_ROOT_STEP:
            begin
                if (root_ge)
                begin
                    x_reg <= x_reg - root_t;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            default:
            begin
            end
        endcase
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.op == msd_pkg::OP_PUBLISH)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (ctl.op == msd_pkg::OP_PUBLISH)
        begin
            out_total_reg <= msd_pkg::TOTAL_W'(n_reg);
            out_mean_reg  <= (n_reg == '0) ? '0 : msd_pkg::VALUE_W'(mean_reg);
            out_sd_reg    <= few ? '0 : sd_val;
            if (few)
            begin
                out_status_reg <= msd_pkg::ST_FEW;
            end
            else if (ovf_reg)
            begin
                out_status_reg <= msd_pkg::ST_OVF;
            end
            else
            begin
                out_status_reg <= msd_pkg::ST_OK;
            end
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.sample_total  = out_total_reg;
    assign results.mean_value    = out_mean_reg;
    assign results.std_deviation = out_sd_reg;
    assign results.status        = out_status_reg;

endmodule

`default_nettype wire

// ===== rtl/msd_controller.sv =====
// state machine that sequences accumulation and the end-of-set arithmetic
`timescale 1ns / 1ps
`default_nettype none

module msd_controller #(
    parameter int MUL_STEPS  = 27,
    parameter int DIV_STEPS  = 53,
    parameter int ROOT_STEPS = 27
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire msd_pkg::msd_sts_t sts,
    output msd_pkg::msd_ctl_t      ctl
);

    localparam int ITER_W = $clog2(DIV_STEPS + 1);

    msd_pkg::msd_state_t state_reg;
    msd_pkg::msd_state_t state_next;
    logic [ITER_W-1:0]   iter_reg;
    logic [ITER_W-1:0]   iter_next;
    logic                iter_done;

    assign iter_done = (iter_reg == '0);

    // state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msd_pkg::S_ACCUM;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        case (state_reg)
            msd_pkg::S_ACCUM:
            begin
                if (sts.last_pending)
                begin
                    state_next = msd_pkg::S_LD_A;
                end
            end
            msd_pkg::S_LD_A:
            begin
                state_next = msd_pkg::S_RUN_A;
                iter_next  = ITER_W'(MUL_STEPS - 1);
            end
            msd_pkg::S_RUN_A:
            begin
                iter_next = iter_reg - ITER_W'(1);
                if (iter_done)
                begin
                    state_next = msd_pkg::S_LD_B;
                end
            end
            msd_pkg::S_LD_B:
            begin
                state_next = msd_pkg::S_RUN_B;
                iter_next  = ITER_W'(MUL_STEPS - 1);
            end
            msd_pkg::S_RUN_B:
            begin
                iter_next = iter_reg - ITER_W'(1);
                if (iter_done)
                begin
                    state_next = msd_pkg::S_LD_D;
                end
            end
            msd_pkg::S_LD_D:
            begin
                state_next = msd_pkg::S_RUN_D;
                iter_next  = ITER_W'(MUL_STEPS - 1);
            end
            msd_pkg::S_RUN_D:
            begin
                iter_next = iter_reg - ITER_W'(1);
                if (iter_done)
                begin
                    state_next = msd_pkg::S_LD_M;
                end
            end
            msd_pkg::S_LD_M:
            begin
                state_next = msd_pkg::S_RUN_M;
                iter_next  = ITER_W'(DIV_STEPS - 1);
            end
            msd_pkg::S_RUN_M:
            begin
                iter_next = iter_reg - ITER_W'(1);
                if (iter_done)
                begin
                    state_next = msd_pkg::S_LD_V;
                end
            end
            msd_pkg::S_LD_V:
            begin
                state_next = msd_pkg::S_RUN_V;
                iter_next  = ITER_W'(DIV_STEPS - 1);
            end
            msd_pkg::S_RUN_V:
            begin
                iter_next = iter_reg - ITER_W'(1);
                if (iter_done)
                begin
                    state_next = msd_pkg::S_LD_R;
                end
            end
            msd_pkg::S_LD_R:
            begin
                state_next = msd_pkg::S_RUN_R;
                iter_next  = ITER_W'(ROOT_STEPS - 1);
            end
            msd_pkg::S_RUN_R:
            begin
                iter_next = iter_reg - ITER_W'(1);
                if (iter_done)
                begin
                    state_next = msd_pkg::S_DONE;
                end
            end
            msd_pkg::S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = msd_pkg::S_ACCUM;
                end
            end
            default:
            begin
                state_next = msd_pkg::S_ACCUM;
            end
        endcase
    end

    // datapath commands
    always_comb
    begin
        ctl.op   = msd_pkg::OP_IDLE;
        ctl.take = 1'b0;
        case (state_reg)
            msd_pkg::S_ACCUM:
            begin
                ctl.take = !sts.last_pending;
            end
            msd_pkg::S_LD_A:
            begin
                ctl.op = msd_pkg::OP_LD_A;
            end
            msd_pkg::S_LD_B:
            begin
                ctl.op = msd_pkg::OP_LD_B;
            end
            msd_pkg::S_LD_D:
            begin
                ctl.op = msd_pkg::OP_LD_D;
            end
            msd_pkg::S_RUN_A, msd_pkg::S_RUN_B, msd_pkg::S_RUN_D:
            begin
                ctl.op = msd_pkg::OP_MUL_STEP;
            end
            msd_pkg::S_LD_M:
            begin
                ctl.op = msd_pkg::OP_LD_M;
            end
            msd_pkg::S_LD_V:
            begin
                ctl.op = msd_pkg::OP_LD_V;
            end
            msd_pkg::S_RUN_M, msd_pkg::S_RUN_V:
            begin
                ctl.op = msd_pkg::OP_DIV_STEP;
            end
            msd_pkg::S_LD_R:
            begin
                ctl.op = msd_pkg::OP_LD_R;
            end
            msd_pkg::S_RUN_R:
            begin
                ctl.op = msd_pkg::OP_ROOT_STEP;
            end
            msd_pkg::S_DONE:
            begin
                if (sts.out_free)
                begin
                    ctl.op = msd_pkg::OP_PUBLISH;
                end
            end
            default:
            begin
                ctl.op = msd_pkg::OP_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/sample_mean_and_std_deviation.sv =====
// top level of the sample mean and standard deviation block
`timescale 1ns / 1ps
`default_nettype none

// Takes one signed Q8.8 sample per cycle while a set is being accumulated
// and, on the sample marked last, produces one result: the sample count, the
// mean truncated toward zero and the sample standard deviation in Q8.8.
// Samples past MAX_SAMPLES are dropped and reported with the overflow status.
// After the last sample is taken, no new sample is accepted until the end-of-set
// arithmetic has run on a single shared shift-add multiplier, a restoring
// divider and a digit-by-digit square root unit, and until any previous result
// has been taken from the result channel.
// The result sits in an output register, so accumulation of the next set may
// begin while it is still waiting on the result channel.
module sample_mean_and_std_deviation #(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input wire logic  clk,
    input wire logic  rst_n,
    msd_in_if.sink    samples,
    msd_out_if.source results
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = CNT_W + SAMPLE_BITS;
    localparam int SQS_W = 2 * SAMPLE_BITS - 1 + CNT_W;
    localparam int NUM_W = (CNT_W + SQS_W > 64) ? 64 : CNT_W + SQS_W;
    localparam int RT_W  = NUM_W + NUM_W % 2;

    msd_pkg::msd_ctl_t ctl;
    msd_pkg::msd_sts_t sts;

    // sequencer
    msd_controller #(
        .MUL_STEPS  (SUM_W),
        .DIV_STEPS  (NUM_W),
        .ROOT_STEPS (RT_W / 2)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .ctl   (ctl)
    );

    // arithmetic and storage
    msd_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .sts     (sts),
        .samples (samples),
        .results (results)
    );

    // a last sample closes the input until the set's result is computed
    a_last_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
        samples.valid && samples.ready && samples.last |=> !samples.ready)
        else $error("input still open after last sample");

    // a set with fewer than two samples reports zero deviation
    a_few_zero_sd: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.status == msd_pkg::ST_FEW
            |-> results.std_deviation == '0)
        else $error("nonzero deviation on short set");

    // only defined status codes are reported
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> results.status == msd_pkg::ST_OK
            || results.status == msd_pkg::ST_FEW
            || results.status == msd_pkg::ST_OVF)
        else $error("undefined status code");

    // a new result is only published while the input side is closed
    a_publish_closed: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.op == msd_pkg::OP_PUBLISH |-> !samples.ready)
        else $error("result published while accepting samples");

endmodule

`default_nettype wire
